// ===== rtl/adct_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, calibration table and control types of the ADC code to temperature unit.
package adct_pkg;

    // Table and field sizes.
    localparam int TABLE_ENTRIES = 34;
    localparam int CODE_BITS     = 12;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TEMP_W        = 15;
    localparam int STATUS_W      = 2;

    // Interpolation result is 500 * fraction, so it always stays below 512.
    localparam int QUO_W         = 9;
    localparam int STEP_W        = $clog2(QUO_W);
    localparam int NUM_W         = CODE_BITS + 11;

    // Temperatures in hundredths of a degree.
    localparam logic [TEMP_W-1:0] COLD_CENTI = TEMP_W'(-4000);
    localparam logic [TEMP_W-1:0] HOT_CENTI  = TEMP_W'(12500);
    localparam logic [TEMP_W-1:0] STEP_CENTI = TEMP_W'(500);
    localparam logic [TEMP_W-1:0] ZERO_CENTI = '0;
    localparam logic [9:0]        NUM_SCALE  = 10'd1000;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COLD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HOT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NODATA = 2'd3;

    // Calibration codes, descending, one per 5 degree step from -40 C.
    localparam logic [CODE_BITS-1:0] CAL_CODES [TABLE_ENTRIES] = '{
        12'd3795, 12'd3787, 12'd3779, 12'd3769, 12'd3761, 12'd3751, 12'd3743,
        12'd3733, 12'd3723, 12'd3713, 12'd3703, 12'd3693, 12'd3683, 12'd3673,
        12'd3663, 12'd3651, 12'd3641, 12'd3629, 12'd3617, 12'd3605, 12'd3593,
        12'd3581, 12'd3569, 12'd3555, 12'd3543, 12'd3529, 12'd3515, 12'd3501,
        12'd3487, 12'd3471, 12'd3457, 12'd3441, 12'd3425, 12'd3409
    };

    // Table read; an index past the end reads as zero.
    function automatic logic [CODE_BITS-1:0] cal_code(input logic [IDX_W:0] idx);
        logic [CODE_BITS-1:0] value;
        value = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (idx == (IDX_W + 1)'(k)) begin
                value = CAL_CODES[k];
            end
        end
        return value;
    endfunction

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SEARCH,
        S_DIVIDE,
        S_WRITE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic set_special;
        logic set_hit;
        logic start_div;
        logic step_idx;
        logic step_div;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;
        logic hit;
        logic in_span;
        logic div_last;
        logic out_free;
    } t_flags;

endpackage

// ===== rtl/adct_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the ADC code to temperature unit.
module adct_ctrl
    import adct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_flags i_flags,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                n_state = i_flags.special ? S_WRITE : S_SEARCH;
            end
            S_SEARCH: begin
                if (i_flags.hit) begin
                    n_state = S_WRITE;
                end else if (i_flags.in_span) begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_flags.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_flags.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and input handshake.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_CLASSIFY: begin
                o_cmd.set_special = i_flags.special;
            end
            S_SEARCH: begin
                if (i_flags.hit) begin
                    o_cmd.set_hit = 1'b1;
                end else if (i_flags.in_span) begin
                    o_cmd.start_div = 1'b1;
                end else begin
                    o_cmd.step_idx = 1'b1;
                end
            end
            S_DIVIDE: begin
                o_cmd.step_div = 1'b1;
            end
            S_WRITE: begin
                o_cmd.load_out = i_flags.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/adct_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the ADC code to temperature unit: table walk, serial divider, output register.
module adct_dpath
    import adct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CODE_BITS-1:0]     i_adc_code,
    input  logic                     i_out_ready,
    input  t_cmd                     i_cmd,
    output t_flags                   o_flags,
    output logic                     o_out_valid,
    output logic signed [TEMP_W-1:0] o_temp_centi,
    output logic [STATUS_W-1:0]      o_status
);

    logic [CODE_BITS-1:0] r_code;
    logic [IDX_W-1:0]     r_idx;
    logic [TEMP_W-1:0]    r_base;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [QUO_W-1:0]     r_quo;
    logic [STEP_W-1:0]    r_step;
    logic [TEMP_W-1:0]    r_res_temp;
    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_out_valid;
    logic [TEMP_W-1:0]    r_out_temp;
    logic [STATUS_W-1:0]  r_out_status;

    logic [CODE_BITS-1:0] hi;
    logic [CODE_BITS-1:0] lo;
    logic [CODE_BITS-1:0] span;
    logic [CODE_BITS-1:0] diff;
    logic [NUM_W-1:0]     num;
    logic [TEMP_W-1:0]    base;
    logic                 rem_ge;
    logic [QUO_W-1:0]     n_quo;
    logic [STATUS_W-1:0]  special_status;
    logic [TEMP_W-1:0]    special_temp;

    // Neighbouring table entries at the current search index.
    always_comb begin
        hi   = cal_code({1'b0, r_idx});
        lo   = cal_code({1'b0, r_idx} + (IDX_W + 1)'(1));
        span = hi - lo;
        diff = hi - r_code;
        num  = NUM_W'(diff) * NUM_W'(NUM_SCALE) + NUM_W'(span);
        base = COLD_CENTI + TEMP_W'(r_idx) * STEP_CENTI;
    end

    // Out-of-table and no-data cases.
    always_comb begin
        special_status = ST_OK;
        special_temp   = ZERO_CENTI;
        if (r_code == '0) begin
            special_status = ST_NODATA;
            special_temp   = ZERO_CENTI;
        end else if (r_code > CAL_CODES[0]) begin
            special_status = ST_COLD;
            special_temp   = COLD_CENTI;
        end else if (r_code < CAL_CODES[TABLE_ENTRIES-1]) begin
            special_status = ST_HOT;
            special_temp   = HOT_CENTI;
        end
    end

    // One restoring division step per cycle.
    always_comb begin
        rem_ge = (r_rem >= r_dsh);
        n_quo  = {r_quo[QUO_W-2:0], rem_ge};
    end

    // Status back to the controller.
    always_comb begin
        o_flags.special  = (special_status != ST_OK);
        o_flags.hit      = (r_code == hi);
        o_flags.in_span  = (r_code > lo);
        o_flags.div_last = (r_step == STEP_W'(QUO_W - 1));
        o_flags.out_free = !r_out_valid || i_out_ready;
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_code <= i_adc_code;
            r_idx  <= '0;
        end
        if (i_cmd.step_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.set_special) begin
            r_res_temp   <= special_temp;
            r_res_status <= special_status;
        end
        if (i_cmd.set_hit) begin
            r_res_temp   <= base;
            r_res_status <= ST_OK;
        end
        if (i_cmd.start_div) begin
            r_base <= base;
            r_rem  <= num;
            r_dsh  <= NUM_W'(span) << QUO_W;
            r_quo  <= '0;
            r_step <= '0;
        end
        if (i_cmd.step_div) begin
            r_rem  <= rem_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quo  <= n_quo;
            r_step <= r_step + STEP_W'(1);
            if (o_flags.div_last) begin
                r_res_temp   <= r_base + TEMP_W'(n_quo);
                r_res_status <= ST_OK;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_temp   <= r_res_temp;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_temp_centi = $signed(r_out_temp);
    assign o_status     = r_out_status;

endmodule

// ===== rtl/adc_code_to_temperature_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ADC code to temperature unit.
//
// Converts one 12-bit sensor code into a temperature in hundredths of a
// degree Celsius by piecewise linear interpolation over a 34-entry table.
// Input channel: i_in_valid / o_in_ready with i_adc_code. Output channel:
// o_out_valid / i_out_ready with o_temp_centi and o_status.
// A request is taken only while the controller is idle. The classify state then
// checks the code; codes outside the table or zero finish at once.
// Otherwise the table is walked one entry per cycle, and a code between two
// entries goes through a 9-step restoring divider, one quotient bit per
// cycle. The write state then loads the output register. Only one request is
// in work at a time: the next is taken after the result has been written.
// The output register holds a finished result while the next request is
// accepted and worked on; a stalled receiver only holds the block at the
// final write step until the earlier result is taken.
// Reset (synchronous, active low) returns the controller to idle and
// empties the output register.
module adc_code_to_temperature_unit
    import adct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CODE_BITS-1:0]     i_adc_code,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [TEMP_W-1:0] o_temp_centi,
    output logic [STATUS_W-1:0]      o_status
);

    t_cmd   cmd;
    t_flags flags;

    // Sequencer.
    adct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Table walk, divider and output register.
    adct_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adc_code   (i_adc_code),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_flags      (flags),
        .o_out_valid  (o_out_valid),
        .o_temp_centi (o_temp_centi),
        .o_status     (o_status)
    );

endmodule

// ===== rtl/adct_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the ADC code to temperature unit, bound to the top level.
module adct_checker
    import adct_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [TEMP_W-1:0] o_temp_centi,
    input logic [STATUS_W-1:0]      o_status
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // After an accepted request the block works before it takes another.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("new request taken while one is in work");

    // No-data results carry zero temperature.
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NODATA) |-> (o_temp_centi == '0))
        else $error("no-data result with non-zero temperature");

    // Saturated results carry the end temperatures of the table.
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_COLD || o_status == ST_HOT) |->
            (o_status == ST_COLD && o_temp_centi == $signed(COLD_CENTI)) ||
            (o_status == ST_HOT && o_temp_centi == $signed(HOT_CENTI)))
        else $error("saturated result with wrong temperature");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind adc_code_to_temperature_unit adct_checker u_adct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_temp_centi (o_temp_centi),
    .o_status     (o_status)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the ADC code to temperature unit.
module testbench;
    import adct_pkg::*;

    // Run control figures; all but the code count are in clock cycles.
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 60;
    localparam int STALL_LIMIT    = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_CODES   = 1250;

    // Interpolation figures in hundredths of a degree.
    localparam int CENTI_AT_FIRST = -4000;
    localparam int CENTI_PER_STEP = 500;

    // One expected reading, with the code that caused it for messages.
    typedef struct packed {
        logic [CODE_BITS-1:0]     code;
        logic signed [TEMP_W-1:0] temp;
        logic [STATUS_W-1:0]      status;
    } t_reading;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [CODE_BITS-1:0]     i_adc_code   = '0;
    logic                     i_out_ready  = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [TEMP_W-1:0] o_temp_centi;
    logic [STATUS_W-1:0]      o_status;

    t_reading pending_readings[$];
    int       error_count = 0;
    int       burst_left  = 1;
    int       hold_left   = 0;
    int       quiet_cycles = 0;

    adc_code_to_temperature_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_adc_code   (i_adc_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_temp_centi (o_temp_centi),
        .o_status     (o_status)
    );

    // Free-running clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Linearises one code: saturation and no-data cases first, then the
    // table walk with interpolation rounded half up.
    function automatic t_reading predict_reading(input logic [CODE_BITS-1:0] code);
        t_reading r;
        int       hi;
        int       lo;
        int       span;
        int       centi;
        r.code   = code;
        r.temp   = '0;
        r.status = ST_OK;
        if (code == '0) begin
            r.temp   = ZERO_CENTI;
            r.status = ST_NODATA;
        end else if (code > CAL_CODES[0]) begin
            r.temp   = COLD_CENTI;
            r.status = ST_COLD;
        end else if (code < CAL_CODES[TABLE_ENTRIES-1]) begin
            r.temp   = HOT_CENTI;
            r.status = ST_HOT;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                hi = int'(CAL_CODES[i]);
                if (int'(code) == hi) begin
                    centi  = CENTI_AT_FIRST + CENTI_PER_STEP * i;
                    r.temp = TEMP_W'(centi);
                    break;
                end
                if (i + 1 < TABLE_ENTRIES) begin
                    lo = int'(CAL_CODES[i+1]);
                    if (int'(code) < hi && int'(code) > lo) begin
                        span   = hi - lo;
                        centi  = CENTI_AT_FIRST + CENTI_PER_STEP * i
                                 + (2 * CENTI_PER_STEP * (hi - int'(code)) + span) / (2 * span);
                        r.temp = TEMP_W'(centi);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Mostly codes inside the table span, with exact entries, both
    // saturation ranges, no-data and the full code range mixed in.
    function automatic logic [CODE_BITS-1:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return CODE_BITS'($urandom_range(CAL_CODES[TABLE_ENTRIES-1], CAL_CODES[0]));
        end else if (sel < 72) begin
            return CAL_CODES[$urandom_range(0, TABLE_ENTRIES - 1)];
        end else if (sel < 80) begin
            return CODE_BITS'($urandom_range(CAL_CODES[0] + 1, (1 << CODE_BITS) - 1));
        end else if (sel < 88) begin
            return CODE_BITS'($urandom_range(1, CAL_CODES[TABLE_ENTRIES-1] - 1));
        end else if (sel < 92) begin
            return '0;
        end
        return CODE_BITS'($urandom);
    endfunction

    // Offers one request and waits for it to be taken. The sender works in
    // bursts; at the end of a burst valid drops for a random gap.
    task automatic send_code(input logic [CODE_BITS-1:0] code);
        int gap;
        i_adc_code <= code;
        if (!i_in_valid) begin
            i_in_valid <= 1'b1;
        end
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 50);
            repeat (gap) @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(30, 80);
            end else begin
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    // Zero, all ones, the table ends and their neighbours, alternating bit
    // patterns and half-way rounding points.
    task automatic test_directed_codes();
        logic [CODE_BITS-1:0] codes[$];
        codes = '{12'd0, 12'd4095, 12'd1, 12'd3796, 12'd3795, 12'd3794, 12'd3786,
                  12'd3410, 12'd3409, 12'd3408, 12'd2048, 12'd2730, 12'd1365,
                  12'd3602, 12'd3599, 12'd3536, 12'd3449, 12'd3700};
        foreach (codes[k]) begin
            send_code(codes[k]);
        end
    endtask

    // Random codes under random sender and receiver idling.
    task automatic test_random_codes(input int count);
        repeat (count) send_code(pick_code());
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        @(negedge i_clk);
        hold_left = LONG_HOLD;
        @(posedge i_clk);
        repeat (6) send_code(pick_code());
    endtask

    // Receiver: a long hold-off when asked, otherwise a ready pattern whose
    // period and duty are redrawn at random intervals, sometimes always ready.
    always @(posedge i_clk) begin
        static int period = 1;
        static int duty = 1;
        static int phase = 0;
        static int pattern_left = 0;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(50, 300);
                phase = 0;
                if ($urandom_range(0, 3) == 0) begin
                    period = 1;
                    duty = 1;
                end else begin
                    period = $urandom_range(2, 8);
                    duty = $urandom_range(1, period - 1);
                end
            end
            pattern_left--;
            i_out_ready <= (phase < duty);
            phase = (phase + 1) % period;
        end
    end

    // Each request taken by the block queues its expected reading.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_readings.push_back(predict_reading(i_adc_code));
        end
    end

    // Each reading handed out is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading: expected none, got temp %0d status %0d",
                         $time, o_temp_centi, o_status);
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temp_centi !== want.temp) begin
                    $display("%0t: temp_centi for code %0d: expected %0d, got %0d",
                             $time, want.code, want.temp, o_temp_centi);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status for code %0d: expected %0d, got %0d",
                             $time, want.code, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Reset, the tests in turn, then the drain and the verdict.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_codes();
        test_random_codes(RANDOM_CODES / 2);
        test_output_backpressure();
        test_random_codes(RANDOM_CODES - RANDOM_CODES / 2);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/adct_pkg.sv
rtl/adct_ctrl.sv
rtl/adct_dpath.sv
rtl/adc_code_to_temperature_unit.sv
rtl/adct_checker.sv
bench/testbench.sv
